// ----- rtl/ptmm_pkg.sv -----
// Package: constants, field structs and codes for the page-table memory manager.
package ptmm_pkg;

  localparam int NUM_PAGES    = 64;
  localparam int PAGE_BYTES   = 256;
  localparam int MAX_PROCS    = 64;
  localparam int TBL_PTR_BASE = 64;
  localparam int OFFSET_W     = 8;
  localparam int MEM_BYTES    = NUM_PAGES * PAGE_BYTES;
  localparam int ADDR_W       = $clog2(MEM_BYTES);
  localparam int PAGE_W       = $clog2(NUM_PAGES);

  localparam logic [1:0] KIND_NEW   = 2'd0;
  localparam logic [1:0] KIND_KILL  = 2'd1;
  localparam logic [1:0] KIND_STORE = 2'd2;
  localparam logic [1:0] KIND_LOAD  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_TBL  = 2'd1;
  localparam logic [1:0] STATUS_NO_DATA = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  process_id;
    logic [6:0]  data_pages;
    logic [13:0] virtual_address;
    logic [7:0]  store_value;
  } ptmm_in_t;

  typedef struct packed {
    logic [13:0] physical_address;
    logic [7:0]  load_value;
    logic [1:0]  status;
  } ptmm_out_t;

endpackage

// ----- rtl/ptmm_ram.sv -----
// Generic single-port RAM with registered read.
module ptmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/page_table_memory_manager_top.sv -----
// Command flow: a store reads the table pointer and the table entry, then writes the byte; a load
// reads the byte instead; a kill walks all 64 table entries, freeing each mapped data page, then its table page.
// A new process takes free pages by a scan of the page-usage bytes from page 0, the table first,
// then each data page; a scan that finds no free page ends the command with an error status.
// One command at a time, accepted only in idle after the result beat; results cannot be stalled.
// After reset a clearing pass writes all 16384 bytes with busy high, leaving byte 0 at one.
module page_table_memory_manager_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ptmm_pkg::ptmm_in_t request,
  output logic               done,
  output ptmm_pkg::ptmm_out_t result
);

  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_SC_RD  = 17'h00004,
    S_SC_CHK = 17'h00008,
    S_TP_WR  = 17'h00010,
    S_ENT_WR = 17'h00020,
    S_PTR_RD = 17'h00040,
    S_PTR_W  = 17'h00080,
    S_KL_RD  = 17'h00100,
    S_KL_CHK = 17'h00200,
    S_KF_RD  = 17'h00400,
    S_KF_W   = 17'h00800,
    S_TE_RD  = 17'h01000,
    S_TE_W   = 17'h02000,
    S_ACC    = 17'h04000,
    S_ACC_W  = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t state, state_next;

  ptmm_pkg::ptmm_in_t req;
  logic [ptmm_pkg::ADDR_W-1:0] clr_cnt;
  logic [ptmm_pkg::PAGE_W-1:0] scan;
  logic                        scan_tbl;
  logic [7:0]                  tbl;
  logic [6:0]                  idx;
  logic [ptmm_pkg::ADDR_W-1:0] paddr;
  logic [7:0]                  loaded;
  logic [1:0]                  status;

  logic                        ram_we;
  logic [ptmm_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_rdata;

  logic [ptmm_pkg::ADDR_W-1:0] ptr_addr;
  logic [ptmm_pkg::ADDR_W-1:0] ent_addr;
  logic [ptmm_pkg::ADDR_W-1:0] te_addr;

  assign ptr_addr = ptmm_pkg::ADDR_W'(ptmm_pkg::TBL_PTR_BASE) +
                    ptmm_pkg::ADDR_W'(req.process_id);
  assign ent_addr = {tbl[ptmm_pkg::PAGE_W-1:0], 1'b0, idx};
  assign te_addr  = {tbl[ptmm_pkg::PAGE_W-1:0], 2'b00,
                     req.virtual_address[ptmm_pkg::ADDR_W-1:ptmm_pkg::OFFSET_W]};

  ptmm_ram #(.WIDTH(8), .DEPTH(ptmm_pkg::MEM_BYTES)) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = (clr_cnt == '0) ? 8'd1 : 8'd0;
      end
      S_SC_RD: ram_addr = ptmm_pkg::ADDR_W'(scan);
      S_SC_CHK: begin
        ram_addr  = ptmm_pkg::ADDR_W'(scan);
        ram_we    = (ram_rdata == 8'd0);
        ram_wdata = 8'd1;
      end
      S_TP_WR: begin
        ram_we    = 1'b1;
        ram_addr  = ptr_addr;
        ram_wdata = tbl;
      end
      S_ENT_WR: begin
        ram_we    = 1'b1;
        ram_addr  = ent_addr;
        ram_wdata = 8'(scan);
      end
      S_PTR_RD, S_KF_RD: ram_addr = ptr_addr;
      S_KL_RD: ram_addr = ent_addr;
      S_KL_CHK: begin
        ram_we   = (ram_rdata != 8'd0);
        ram_addr = ptmm_pkg::ADDR_W'(ram_rdata);
      end
      S_KF_W: begin
        ram_we   = 1'b1;
        ram_addr = ptmm_pkg::ADDR_W'(ram_rdata);
      end
      S_TE_RD: ram_addr = te_addr;
      S_ACC: begin
        ram_addr  = paddr;
        ram_we    = (req.kind == ptmm_pkg::KIND_STORE);
        ram_wdata = req.store_value;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_next = (request.kind == ptmm_pkg::KIND_NEW) ? S_SC_RD : S_PTR_RD;
        end
      end
      S_SC_RD:  state_next = S_SC_CHK;
      S_SC_CHK: begin
        if (ram_rdata == 8'd0) begin
          state_next = scan_tbl ? S_TP_WR : S_ENT_WR;
        end else if (scan == '1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SC_RD;
        end
      end
      S_TP_WR:  state_next = (req.data_pages == '0) ? S_DONE : S_SC_RD;
      S_ENT_WR: state_next = (7'(idx + 7'd1) == req.data_pages) ? S_DONE : S_SC_RD;
      S_PTR_RD: state_next = S_PTR_W;
      S_PTR_W:  state_next = (req.kind == ptmm_pkg::KIND_KILL) ? S_KL_RD : S_TE_RD;
      S_KL_RD:  state_next = S_KL_CHK;
      S_KL_CHK: state_next = (idx == 7'(ptmm_pkg::NUM_PAGES - 1)) ? S_KF_RD : S_KL_RD;
      S_KF_RD:  state_next = S_KF_W;
      S_KF_W:   state_next = S_DONE;
      S_TE_RD:  state_next = S_TE_W;
      S_TE_W:   state_next = S_ACC;
      S_ACC:    state_next = (req.kind == ptmm_pkg::KIND_STORE) ? S_DONE : S_ACC_W;
      S_ACC_W:  state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req      <= request;
        scan     <= '0;
        scan_tbl <= 1'b1;
        idx      <= '0;
        paddr    <= '0;
        loaded   <= '0;
        status   <= ptmm_pkg::STATUS_OK;
      end
      S_SC_CHK: begin
        if (ram_rdata == 8'd0) begin
          if (scan_tbl) begin
            tbl <= 8'(scan);
          end
        end else begin
          scan <= scan + 1'b1;
          if (scan == '1) begin
            status <= scan_tbl ? ptmm_pkg::STATUS_NO_TBL : ptmm_pkg::STATUS_NO_DATA;
          end
        end
      end
      S_TP_WR: begin
        scan_tbl <= 1'b0;
        scan     <= '0;
      end
      S_ENT_WR: begin
        idx  <= idx + 1'b1;
        scan <= '0;
      end
      S_PTR_W:  tbl <= ram_rdata;
      S_KL_CHK: idx <= idx + 1'b1;
      S_TE_W:   paddr <= {ram_rdata[ptmm_pkg::PAGE_W-1:0],
                          req.virtual_address[ptmm_pkg::OFFSET_W-1:0]};
      S_ACC_W:  loaded <= ram_rdata;
      default: ;
    endcase
  end

  assign busy                    = (state != S_IDLE);
  assign done                    = (state == S_DONE);
  assign result.physical_address = paddr;
  assign result.load_value       = loaded;
  assign result.status           = status;

endmodule

// ----- rtl/ptmm_checker.sv -----
// Port checker for the page-table memory manager, bound to the top level.
module ptmm_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input ptmm_pkg::ptmm_out_t result
);

  // a result beat only ends a command in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while idle");

  a_accept: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("result beat not followed by idle");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3))
    else $error("undefined status code");

  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done)
    else $error("result beat without a command");

endmodule

bind page_table_memory_manager_top ptmm_checker u_ptmm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

// ----- verif/tb_top.sv -----
// Testbench for the page-table memory manager: queue-fed driver, monitor, byte-memory predictor.
module tb_top;
  import ptmm_pkg::*;

  localparam int NUM_RANDOM  = 1880;
  localparam int CYCLE_LIMIT = 100000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  logic      done;
  ptmm_in_t  request = '0;
  ptmm_out_t result;

  ptmm_in_t  pending_cmds[$];
  ptmm_out_t expected_results[$];
  int        total_cmds = 0;
  int        accepted_cmds = 0;
  int        errors = 0;
  int        cycles = 0;

  // shadow of the managed byte memory
  logic [7:0] shadow_mem [0:MEM_BYTES-1];
  // pages requested per process at generation time, -1 when none
  int         alloc_pages [0:MAX_PROCS-1];

  page_table_memory_manager_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int byte_addr(int page, int off);
    return (page * PAGE_BYTES + off) % MEM_BYTES;
  endfunction

  function automatic int claim_free_page();
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (shadow_mem[byte_addr(0, p)] == 8'd0) begin
        shadow_mem[byte_addr(0, p)] = 8'd1;
        return p;
      end
    end
    return -1;
  endfunction

  function automatic int table_page(int pid);
    return shadow_mem[byte_addr(0, TBL_PTR_BASE + pid)];
  endfunction

  function automatic int translate_addr(int pid, int vaddr);
    int ppage;
    ppage = shadow_mem[byte_addr(table_page(pid), vaddr / PAGE_BYTES)];
    return byte_addr(ppage, vaddr % PAGE_BYTES);
  endfunction

  task automatic predict_command(input ptmm_in_t cmd);
    ptmm_out_t res;
    int        pid;
    int        tbl;
    int        pg;
    res = '0;
    pid = cmd.process_id % MAX_PROCS;
    case (cmd.kind)
      KIND_NEW: begin
        tbl = claim_free_page();
        if (tbl < 0) begin
          res.status = STATUS_NO_TBL;
        end else begin
          shadow_mem[byte_addr(0, TBL_PTR_BASE + pid)] = tbl[7:0];
          for (int i = 0; i < cmd.data_pages; i++) begin
            pg = claim_free_page();
            if (pg < 0) begin
              res.status = STATUS_NO_DATA;
              break;
            end
            shadow_mem[byte_addr(tbl, i)] = pg[7:0];
          end
        end
      end
      KIND_KILL: begin
        tbl = table_page(pid);
        for (int i = 0; i < NUM_PAGES; i++) begin
          pg = shadow_mem[byte_addr(tbl, i)];
          if (pg != 0) shadow_mem[byte_addr(0, pg)] = 8'd0;
        end
        shadow_mem[byte_addr(0, table_page(pid))] = 8'd0;
      end
      KIND_STORE: begin
        pg = translate_addr(pid, cmd.virtual_address);
        shadow_mem[pg] = cmd.store_value;
        res.physical_address = pg[13:0];
      end
      default: begin
        pg = translate_addr(pid, cmd.virtual_address);
        res.physical_address = pg[13:0];
        res.load_value = shadow_mem[pg];
      end
    endcase
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic ptmm_in_t make_cmd(logic [1:0] kind, int pid, int cnt, int vaddr,
                                        int value);
    ptmm_in_t c;
    c.kind = kind;
    c.process_id = pid[5:0];
    c.data_pages = cnt[6:0];
    c.virtual_address = vaddr[13:0];
    c.store_value = value[7:0];
    return c;
  endfunction

  task automatic add_random_cmd();
    int       roll;
    int       pid;
    int       cnt;
    int       vaddr;
    ptmm_in_t c;
    roll = $urandom_range(99);
    pid = $urandom_range(MAX_PROCS - 1);
    vaddr = $urandom_range(MEM_BYTES - 1);
    if (roll < 22) begin
      // mostly small processes; a few large ones drain memory
      cnt = ($urandom_range(29) == 0) ? $urandom_range(64) : $urandom_range(4);
      alloc_pages[pid] = cnt;
      c = make_cmd(KIND_NEW, pid, cnt, vaddr, $urandom_range(255));
    end else if (roll < 38) begin
      alloc_pages[pid] = -1;
      c = make_cmd(KIND_KILL, pid, $urandom_range(127), vaddr, $urandom_range(255));
    end else begin
      // aim most accesses at mapped pages of a known process
      if ($urandom_range(3) != 0) begin
        for (int t = 0; t < 8 && alloc_pages[pid] <= 0; t++)
          pid = $urandom_range(MAX_PROCS - 1);
        if (alloc_pages[pid] > 0)
          vaddr = $urandom_range(alloc_pages[pid] - 1) * PAGE_BYTES + $urandom_range(255);
      end
      c = make_cmd((roll < 69) ? KIND_STORE : KIND_LOAD, pid, $urandom_range(127), vaddr,
                   $urandom_range(255));
    end
    pending_cmds.push_back(c);
  endtask

  // driver: one assignment per signal per edge
  always @(posedge clk) begin
    int idle_pct;
    if (!rst) begin
      if (start && !busy) begin
        predict_command(request);
        accepted_cmds++;
      end
      if (!start || !busy) begin
        idle_pct = (accepted_cmds < total_cmds / 3) ? 32 :
                   (accepted_cmds < 2 * total_cmds / 3) ? 50 : 0;
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          request <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each result beat checked against the oldest expectation
  always @(posedge clk) begin
    ptmm_out_t want;
    cycles++;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("result beat with nothing expected (cycle %0d)", cycles);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.physical_address !== want.physical_address)
          report_mismatch("physical_address", result.physical_address,
                          want.physical_address);
        if (result.load_value !== want.load_value)
          report_mismatch("load_value", result.load_value, want.load_value);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'd0;
    shadow_mem[0] = 8'd1;
    for (int i = 0; i < MAX_PROCS; i++) alloc_pages[i] = -1;

    // directed: kill of an unknown process, fills, exhaustion, edge addresses
    pending_cmds.push_back(make_cmd(KIND_LOAD, 7, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_NEW, 0, 3, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_STORE, 0, 0, 16'h0000, 8'hff));
    pending_cmds.push_back(make_cmd(KIND_STORE, 0, 0, 2 * PAGE_BYTES + 255, 8'h5a));
    pending_cmds.push_back(make_cmd(KIND_LOAD, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_LOAD, 0, 0, 2 * PAGE_BYTES + 255, 0));
    pending_cmds.push_back(make_cmd(KIND_STORE, 63, 127, 16383, 255));
    pending_cmds.push_back(make_cmd(KIND_LOAD, 63, 127, 16383, 255));
    pending_cmds.push_back(make_cmd(KIND_NEW, 63, 64, 16383, 255));
    pending_cmds.push_back(make_cmd(KIND_NEW, 5, 1, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_NEW, 6, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_LOAD, 63, 0, 40 * PAGE_BYTES + 17, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 63, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_NEW, 6, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 40, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_NEW, 1, 2, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_STORE, 1, 0, PAGE_BYTES + 1, 8'haa));
    pending_cmds.push_back(make_cmd(KIND_LOAD, 1, 0, PAGE_BYTES + 1, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 6, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_NEW, 2, 64, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_KILL, 2, 0, 0, 0));
    for (int i = 0; i < NUM_RANDOM; i++) add_random_cmd();
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_cmds == total_cmds && expected_results.size() == 0);
    // drain: run on after the last result beat before the final check
    repeat (20000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
